FILE: hw/rtl/r4s_pkg.sv
// Shared widths, register indexes, action codes and controller/datapath interface types.
package r4s_pkg;

	// Field widths
	localparam int OFS_W      = 48;
	localparam int LEN_W      = 25;
	localparam int BSZ_W      = 17;
	localparam int DEV_W      = 4;
	localparam int DCNT_W     = 5;
	localparam int MASK_W     = 16;
	localparam int BLK_W      = 32;
	localparam int ACT_W      = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	// Stream packing
	localparam int S_TDATA_W = 80;
	localparam int S_TUSER_W = 1;
	localparam int M_TDATA_W = 128;
	localparam int M_TUSER_W = 4;

	// Array limits and register reset values
	localparam int MAX_DEVICES  = 16;
	localparam int MIN_DEVICES  = 3;
	localparam int MAX_SEGMENTS = 64;
	localparam int BSZ_MAX      = 65536;
	localparam int BSZ_RESET    = 512;
	localparam int DCNT_RESET   = 3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEVICE_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MISSING_MASK = 2'd2;

	// Segment action codes
	localparam logic [ACT_W-1:0] ACT_READ_DIRECT  = 3'd0;
	localparam logic [ACT_W-1:0] ACT_READ_RECON   = 3'd1;
	localparam logic [ACT_W-1:0] ACT_WRITE_RMW    = 3'd2;
	localparam logic [ACT_W-1:0] ACT_WRITE_PARITY = 3'd3;
	localparam logic [ACT_W-1:0] ACT_WRITE_DATA   = 3'd4;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic div_start_a;
		logic div_take_a;
		logic div_start_b;
		logic div_take_b;
		logic mul_step;
		logic seg_load;
		logic seg_last;
		logic seg_trunc;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic len_zero;
		logic div_done;
		logic final_seg;
	} sts_t;

endpackage

FILE: hw/rtl/r4s_div.sv
// Restoring divider, one quotient bit per cycle, shared by both address divisions.
module r4s_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [r4s_pkg::OFS_W-1:0]   dividend,
	input  logic [r4s_pkg::BSZ_W-1:0]   divisor,
	output logic                        done,
	output logic [r4s_pkg::OFS_W-1:0]   quotient,
	output logic [r4s_pkg::BSZ_W-1:0]   remainder
);

	localparam int CNT_W = $clog2(r4s_pkg::OFS_W);

	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [r4s_pkg::OFS_W-1:0]   quo_q;
	logic [r4s_pkg::BSZ_W-1:0]   rem_q;
	logic [r4s_pkg::BSZ_W-1:0]   dsr_q;
	logic [r4s_pkg::BSZ_W:0]     trial;
	logic                        ge;
	logic [r4s_pkg::BSZ_W:0]     diff;

	// One trial subtraction per cycle, dividend bits enter MSB first
	assign trial = {rem_q, quo_q[r4s_pkg::OFS_W-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	// Sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(r4s_pkg::OFS_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Partial remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[r4s_pkg::OFS_W-2:0], ge};
			rem_q <= ge ? diff[r4s_pkg::BSZ_W-1:0] : trial[r4s_pkg::BSZ_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

FILE: hw/rtl/r4s_dp.sv
// Datapath: configuration registers, address arithmetic, segment generation and output register.
module r4s_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [r4s_pkg::CFG_IDX_W-1:0]    cfg_addr,
	input  logic [r4s_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                             in_func,
	input  logic [r4s_pkg::OFS_W-1:0]        in_byte_offset,
	input  logic [r4s_pkg::LEN_W-1:0]        in_request_length,
	input  r4s_pkg::cmd_t                    cmd,
	output r4s_pkg::sts_t                    sts,
	output logic [r4s_pkg::DEV_W-1:0]        device_index,
	output logic [r4s_pkg::OFS_W-1:0]        device_byte_offset,
	output logic [r4s_pkg::BLK_W-1:0]        device_block_index,
	output logic [r4s_pkg::BSZ_W-1:0]        segment_length,
	output logic [r4s_pkg::LEN_W-1:0]        buffer_position,
	output logic [r4s_pkg::ACT_W-1:0]        action,
	output logic                             last_segment,
	output logic                             truncated
);

	localparam int OW = r4s_pkg::OFS_W;
	localparam int LW = r4s_pkg::LEN_W;
	localparam int BW = r4s_pkg::BSZ_W;
	localparam int DW = r4s_pkg::DEV_W;
	localparam int CW = r4s_pkg::DCNT_W;

	// Configuration registers
	logic [BW-1:0]               block_bytes_q;
	logic [CW-1:0]               device_count_q;
	logic [r4s_pkg::MASK_W-1:0]  missing_mask_q;

	// Request state
	logic           func_q;
	logic [OW-1:0]  ofs_q;
	logic [LW-1:0]  rem_len_q;
	logic [LW-1:0]  pos_q;
	logic [BW-1:0]  in_blk_q;
	logic [OW-1:0]  dblk_q;
	logic [DW-1:0]  dev_q;
	logic [OW-1:0]  base_q;
	logic [BW-1:0]  mb_q;

	// Output register
	logic [DW-1:0]                 out_dev_q;
	logic [OW-1:0]                 out_ofs_q;
	logic [r4s_pkg::BLK_W-1:0]     out_blk_q;
	logic [BW-1:0]                 out_len_q;
	logic [LW-1:0]                 out_pos_q;
	logic [r4s_pkg::ACT_W-1:0]     out_act_q;
	logic                          out_last_q;
	logic                          out_trunc_q;

	// Clamped configuration
	logic [BW-1:0]  bsz;
	logic [CW-1:0]  dcnt;
	logic [CW-1:0]  dcnt_m1;
	logic [DW-1:0]  par_dev;
	logic           dev_wrap;

	// Divider hookup
	logic           div_start;
	logic [OW-1:0]  div_dividend;
	logic [BW-1:0]  div_divisor;
	logic           div_done;
	logic [OW-1:0]  div_quo;
	logic [BW-1:0]  div_rem;

	// Segment terms
	logic [BW-1:0]                 room;
	logic                          rem_short;
	logic [BW-1:0]                 seg;
	logic                          dev_miss;
	logic                          par_miss;
	logic [r4s_pkg::ACT_W-1:0]     act;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_bytes_q  <= BW'(r4s_pkg::BSZ_RESET);
			device_count_q <= CW'(r4s_pkg::DCNT_RESET);
			missing_mask_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				r4s_pkg::REG_BLOCK_BYTES:  block_bytes_q  <= cfg_wdata;
				r4s_pkg::REG_DEVICE_COUNT: device_count_q <= cfg_wdata[CW-1:0];
				r4s_pkg::REG_MISSING_MASK: missing_mask_q <= cfg_wdata[r4s_pkg::MASK_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp block size and device count into range
	always_comb begin
		if (block_bytes_q == '0)
			bsz = BW'(1);
		else if (block_bytes_q > BW'(r4s_pkg::BSZ_MAX))
			bsz = BW'(r4s_pkg::BSZ_MAX);
		else
			bsz = block_bytes_q;
		if (device_count_q < CW'(r4s_pkg::MIN_DEVICES))
			dcnt = CW'(r4s_pkg::MIN_DEVICES);
		else if (device_count_q > CW'(r4s_pkg::MAX_DEVICES))
			dcnt = CW'(r4s_pkg::MAX_DEVICES);
		else
			dcnt = device_count_q;
	end

	// Parity device index equals the number of data devices
	assign dcnt_m1  = dcnt - CW'(1);
	assign par_dev  = dcnt_m1[DW-1:0];
	assign dev_wrap = dev_q == (par_dev - DW'(1));

	// Divider operand select: offset by block size, then block by data devices
	assign div_start    = cmd.div_start_a | cmd.div_start_b;
	assign div_dividend = cmd.div_start_a ? ofs_q : dblk_q;
	assign div_divisor  = cmd.div_start_a ? bsz : BW'(par_dev);

	r4s_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Current segment: length, end of request, action
	assign room      = bsz - in_blk_q;
	assign rem_short = rem_len_q < LW'(room);
	assign seg       = rem_short ? rem_len_q[BW-1:0] : room;
	assign dev_miss  = missing_mask_q[dev_q];
	assign par_miss  = missing_mask_q[par_dev];

	always_comb begin
		if (func_q) begin
			if (dev_miss)
				act = r4s_pkg::ACT_WRITE_PARITY;
			else if (par_miss)
				act = r4s_pkg::ACT_WRITE_DATA;
			else
				act = r4s_pkg::ACT_WRITE_RMW;
		end else begin
			act = dev_miss ? r4s_pkg::ACT_READ_RECON : r4s_pkg::ACT_READ_DIRECT;
		end
	end

	// Request registers, address arithmetic and output register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q    <= in_func;
			ofs_q     <= in_byte_offset;
			rem_len_q <= in_request_length;
			pos_q     <= '0;
		end
		if (cmd.div_take_a) begin
			dblk_q   <= div_quo;
			in_blk_q <= div_rem;
		end
		if (cmd.div_take_b) begin
			dblk_q <= div_quo;
			dev_q  <= div_rem[DW-1:0];
			base_q <= '0;
			mb_q   <= bsz;
		end
		// Shift-add multiply, block size bits MSB first
		if (cmd.mul_step) begin
			base_q <= {base_q[OW-2:0], 1'b0} + (mb_q[BW-1] ? dblk_q : '0);
			mb_q   <= {mb_q[BW-2:0], 1'b0};
		end
		if (cmd.seg_load) begin
			out_dev_q   <= dev_q;
			out_ofs_q   <= base_q + OW'(in_blk_q);
			out_blk_q   <= dblk_q[r4s_pkg::BLK_W-1:0];
			out_len_q   <= seg;
			out_pos_q   <= pos_q;
			out_act_q   <= act;
			out_last_q  <= cmd.seg_last;
			out_trunc_q <= cmd.seg_trunc;
			rem_len_q   <= rem_len_q - LW'(seg);
			pos_q       <= pos_q + LW'(seg);
			in_blk_q    <= '0;
			// Step to the next data device, wrapping to device 0 of the next array block
			if (dev_wrap) begin
				dev_q  <= '0;
				dblk_q <= dblk_q + OW'(1);
				base_q <= base_q + OW'(bsz);
			end else begin
				dev_q <= dev_q + DW'(1);
			end
		end
	end

	assign sts.len_zero  = rem_len_q == '0;
	assign sts.div_done  = div_done;
	assign sts.final_seg = !(rem_len_q > LW'(room));

	assign device_index       = out_dev_q;
	assign device_byte_offset = out_ofs_q;
	assign device_block_index = out_blk_q;
	assign segment_length     = out_len_q;
	assign buffer_position    = out_pos_q;
	assign action             = out_act_q;
	assign last_segment       = out_last_q;
	assign truncated          = out_trunc_q;

endmodule

FILE: hw/rtl/r4s_ctrl.sv
// Controller: request sequencing through the divisions, the multiply and segment emission.
module r4s_ctrl #(
	parameter int MAX_SEGMENTS = r4s_pkg::MAX_SEGMENTS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_valid,
	output logic            s_ready,
	output logic            m_valid,
	input  logic            m_ready,
	input  r4s_pkg::sts_t   sts,
	output r4s_pkg::cmd_t   cmd
);

	localparam int SEG_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int MUL_W = $clog2(r4s_pkg::BSZ_W);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DIV_A  = 3'd1;
	localparam logic [2:0] ST_WAIT_A = 3'd2;
	localparam logic [2:0] ST_DIV_B  = 3'd3;
	localparam logic [2:0] ST_WAIT_B = 3'd4;
	localparam logic [2:0] ST_MUL    = 3'd5;
	localparam logic [2:0] ST_EMIT   = 3'd6;

	logic [2:0]       state_q;
	logic [2:0]       state_d;
	logic [SEG_W-1:0] seg_cnt_q;
	logic [MUL_W-1:0] mul_cnt_q;
	logic             m_valid_q;
	logic             out_free;
	logic             seg_max;

	assign s_ready  = state_q == ST_IDLE;
	assign m_valid  = m_valid_q;
	assign out_free = !m_valid_q || m_ready;
	assign seg_max  = seg_cnt_q == SEG_W'(MAX_SEGMENTS - 1);

	// Next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DIV_A;
				end
			end
			ST_DIV_A: begin
				// Zero-length request yields no segments
				if (sts.len_zero) begin
					state_d = ST_IDLE;
				end else begin
					cmd.div_start_a = 1'b1;
					state_d         = ST_WAIT_A;
				end
			end
			ST_WAIT_A: begin
				if (sts.div_done) begin
					cmd.div_take_a = 1'b1;
					state_d        = ST_DIV_B;
				end
			end
			ST_DIV_B: begin
				cmd.div_start_b = 1'b1;
				state_d         = ST_WAIT_B;
			end
			ST_WAIT_B: begin
				if (sts.div_done) begin
					cmd.div_take_b = 1'b1;
					state_d        = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				if (mul_cnt_q == MUL_W'(r4s_pkg::BSZ_W - 1))
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.seg_load  = 1'b1;
					cmd.seg_last  = sts.final_seg || seg_max;
					cmd.seg_trunc = seg_max && !sts.final_seg;
					if (cmd.seg_last)
						state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State, counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			seg_cnt_q <= '0;
			mul_cnt_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.div_take_b) begin
				seg_cnt_q <= '0;
				mul_cnt_q <= '0;
			end
			if (cmd.mul_step)
				mul_cnt_q <= mul_cnt_q + MUL_W'(1);
			if (cmd.seg_load)
				seg_cnt_q <= seg_cnt_q + SEG_W'(1);
			if (cmd.seg_load)
				m_valid_q <= 1'b1;
			else if (m_ready)
				m_valid_q <= 1'b0;
		end
	end

endmodule

FILE: hw/rtl/raid4_request_splitter.sv
// RAID4 request splitter top level: stream ports, configuration port, controller and datapath.
// Before the first registered segment, a request passes through two 48-step bit-serial
// divisions in the shared divider and then a 17-step shift-add multiply.
// Throughput: then one segment per cycle while the output is taken; a new request is
// accepted the cycle after the last segment is registered; zero-length ones skip the divider.
// Reset: arst_n asynchronous active low; control state idle, registers back to 512 / 3 / 0.
module raid4_request_splitter #(
	parameter int MAX_SEGMENTS = r4s_pkg::MAX_SEGMENTS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [r4s_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  logic [r4s_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// byte_offset [47:0], request_length [72:48], zero fill [79:73]
	input  logic [r4s_pkg::S_TDATA_W-1:0]     s_axis_tdata,
	// func [0]
	input  logic [r4s_pkg::S_TUSER_W-1:0]     s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// device_index [3:0], device_byte_offset [51:4], device_block_index [83:52],
	// segment_length [100:84], buffer_position [125:101], zero fill [127:126]
	output logic [r4s_pkg::M_TDATA_W-1:0]     m_axis_tdata,
	// action [2:0], truncated [3]
	output logic [r4s_pkg::M_TUSER_W-1:0]     m_axis_tuser,
	// last_segment
	output logic                              m_axis_tlast
);

	r4s_pkg::cmd_t cmd;
	r4s_pkg::sts_t sts;

	logic [r4s_pkg::DEV_W-1:0]  device_index;
	logic [r4s_pkg::OFS_W-1:0]  device_byte_offset;
	logic [r4s_pkg::BLK_W-1:0]  device_block_index;
	logic [r4s_pkg::BSZ_W-1:0]  segment_length;
	logic [r4s_pkg::LEN_W-1:0]  buffer_position;
	logic [r4s_pkg::ACT_W-1:0]  action;
	logic                       truncated;

	r4s_ctrl #(
		.MAX_SEGMENTS (MAX_SEGMENTS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	r4s_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_wr_en          (cfg_wr_en),
		.cfg_addr           (cfg_addr),
		.cfg_wdata          (cfg_wdata),
		.in_func            (s_axis_tuser[0]),
		.in_byte_offset     (s_axis_tdata[r4s_pkg::OFS_W-1:0]),
		.in_request_length  (s_axis_tdata[r4s_pkg::OFS_W+r4s_pkg::LEN_W-1:r4s_pkg::OFS_W]),
		.cmd                (cmd),
		.sts                (sts),
		.device_index       (device_index),
		.device_byte_offset (device_byte_offset),
		.device_block_index (device_block_index),
		.segment_length     (segment_length),
		.buffer_position    (buffer_position),
		.action             (action),
		.last_segment       (m_axis_tlast),
		.truncated          (truncated)
	);

	// Output transaction packing
	assign m_axis_tdata = {2'b00, buffer_position, segment_length, device_block_index,
		device_byte_offset, device_index};
	assign m_axis_tuser = {truncated, action};

`ifndef SYNTHESIS
	// Every emitted segment carries at least one byte
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[100:84] != '0))
		else $error("zero-length segment emitted");

	// Truncation is only flagged on the closing segment
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[3]) |-> m_axis_tlast)
		else $error("truncated flag without last segment");

	// A zero-length request returns to idle without starting the divider
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && (s_axis_tdata[72:48] == '0)) |-> ##2 s_axis_tready)
		else $error("zero-length request not dropped");

	// Segments are only loaded in the emission phase, never while idle
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !cmd.seg_load)
		else $error("segment loaded while idle");
`endif

endmodule
